[hw/rtl/mrtu_pkg.sv]
// Shared types, constants and functions for the Modbus RTU frame receiver.
package mrtu_pkg;

  localparam int FRAME_BYTES     = 125;
  localparam int COUNT_W         = $clog2(FRAME_BYTES + 1);
  localparam int HDR_BYTES       = 6;
  localparam int MIN_FRAME_BYTES = 4;

  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [18:0] WRITE_LOW  = 19'h7FA6C;
  localparam logic [18:0] WRITE_HIGH = 19'h7FFFF;
  localparam logic [2:0]  WRITE_PAGE = 3'h7;
  localparam logic [7:0]  FN_READ    = 8'd3;
  localparam logic [7:0]  FN_WRITE   = 8'd6;

  localparam logic [7:0]  RST_SLAVE_ADDRESS   = 8'd1;
  localparam logic [2:0]  RST_READ_PAGE       = 3'd0;
  localparam logic [15:0] RST_CHAR_GAP_TICKS  = 16'd3468;
  localparam logic [15:0] RST_FRAME_END_TICKS = 16'd8092;

  typedef enum logic [2:0] {
    ST_READ_OK   = 3'd0,
    ST_WRITE_OK  = 3'd1,
    ST_OTHER_FN  = 3'd2,
    ST_TIMING    = 3'd3,
    ST_CRC       = 3'd4,
    ST_ADDRESS   = 3'd5,
    ST_PROTECTED = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CFG_SLAVE_ADDRESS   = 2'd0,
    CFG_READ_PAGE       = 2'd1,
    CFG_CHAR_GAP_TICKS  = 2'd2,
    CFG_FRAME_END_TICKS = 2'd3
  } cfg_index_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [2:0]  read_page;
    logic [15:0] char_gap_ticks;
    logic [15:0] frame_end_ticks;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  // One byte of CRC-16, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/mrtu_rx_if.sv]
// Input item channel: received bytes and timer ticks.
interface mrtu_rx_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

[hw/rtl/mrtu_res_if.sv]
// Result item channel: one verdict per frame.
interface mrtu_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  function_code;
  logic [18:0] start_address;
  logic [15:0] word_value;
  logic [7:0]  resp_byte_count;
  logic [6:0]  frame_length;

  modport source (output valid, output status, output function_code, output start_address,
                  output word_value, output resp_byte_count, output frame_length,
                  input ready);
  modport sink (input valid, input status, input function_code, input start_address,
                input word_value, input resp_byte_count, input frame_length,
                output ready);
endinterface

[hw/rtl/mrtu_cfg_if.sv]
// Configuration write channel.
interface mrtu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[hw/rtl/modbus_rtu_frame_receiver.sv]
// Top level of the Modbus RTU slave frame receiver.
//
// rx carries one item per handshake: a received byte (req_type 0) or one
// timer tick (req_type 1). res carries one verdict per frame, produced on the
// tick that ends the frame. cfg writes the four setup registers (slave
// address, read page, gap ticks, end ticks) and is always ready.
//
// Throughput is one item per clock while res is not stalled. An accepted
// item is held in the input register, and the verdict of a frame-ending
// tick is then loaded into the result register. The byte-wide CRC update
// and verdict decode lie between those registers.
//
// If res is stalled with a verdict waiting, items flow until the input
// register holds the next item; rx.ready then drops until res is taken.
// Reset returns the registers to defaults, idles the engine and empties both
// stages.
module modbus_rtu_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  mrtu_rx_if.sink    rx,
  mrtu_res_if.source res,
  mrtu_cfg_if.sink   cfg
);

  mrtu_pkg::cfg_t  regs;
  mrtu_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  mrtu_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mrtu_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  mrtu_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res        (res)
  );

endmodule

[hw/rtl/mrtu_cfg_regs.sv]
// Configuration register file.
module mrtu_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  mrtu_cfg_if.sink       cfg,
  output mrtu_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.slave_address   <= mrtu_pkg::RST_SLAVE_ADDRESS;
      regs.read_page       <= mrtu_pkg::RST_READ_PAGE;
      regs.char_gap_ticks  <= mrtu_pkg::RST_CHAR_GAP_TICKS;
      regs.frame_end_ticks <= mrtu_pkg::RST_FRAME_END_TICKS;
    end else if (cfg.valid) begin
      case (mrtu_pkg::cfg_index_t'(cfg.reg_index))
        mrtu_pkg::CFG_SLAVE_ADDRESS:   regs.slave_address   <= cfg.wdata[7:0];
        mrtu_pkg::CFG_READ_PAGE:       regs.read_page       <= cfg.wdata[2:0];
        mrtu_pkg::CFG_CHAR_GAP_TICKS:  regs.char_gap_ticks  <= cfg.wdata;
        mrtu_pkg::CFG_FRAME_END_TICKS: regs.frame_end_ticks <= cfg.wdata;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/mrtu_in_reg.sv]
// Input register stage between the item channel and the frame engine.
module mrtu_in_reg (
  input  logic            clk,
  input  logic            rst,
  mrtu_rx_if.sink         rx,
  output logic            item_valid,
  output mrtu_pkg::item_t item,
  input  logic            item_ready
);

  logic take;

  assign rx.ready = !item_valid || item_ready;
  assign take     = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.req_type <= rx.req_type;
      item.rx_byte  <= rx.rx_byte;
    end
  end

endmodule

[hw/rtl/mrtu_frame_core.sv]
// Frame state, timers, CRC check, verdict decode and result register.
module mrtu_frame_core (
  input  logic            clk,
  input  logic            rst,
  input  mrtu_pkg::cfg_t  regs,
  input  logic            item_valid,
  input  mrtu_pkg::item_t item,
  output logic            item_ready,
  mrtu_res_if.source      res
);

  localparam int CW = mrtu_pkg::COUNT_W;

  logic [7:0]    header_bytes [mrtu_pkg::HDR_BYTES];
  logic [CW-1:0] rx_count;
  logic [15:0]   crc_acc;
  logic [15:0]   gap_timer;
  logic [15:0]   end_timer;
  logic [1:0]    gap_expiries;
  logic          in_frame;
  logic          overflowed;

  logic [7:0]    header_bytes_next [mrtu_pkg::HDR_BYTES];
  logic [CW-1:0] rx_count_next;
  logic [15:0]   crc_acc_next;
  logic [15:0]   gap_timer_next;
  logic [15:0]   end_timer_next;
  logic [1:0]    gap_expiries_next;
  logic          in_frame_next;
  logic          overflowed_next;

  logic          fire;
  logic          emit;
  logic [15:0]   gap_inc;
  logic [15:0]   end_inc;
  logic [15:0]   reg_addr;
  logic [15:0]   val;
  logic [18:0]   wr_addr;

  mrtu_pkg::status_t st;
  logic [18:0]   addr_out;
  logic [15:0]   word_out;
  logic [7:0]    cnt_out;

  assign item_ready = !res.valid || res.ready;
  assign fire       = item_valid && item_ready;
  assign gap_inc    = gap_timer + 16'd1;
  assign end_inc    = end_timer + 16'd1;

  always_comb begin
    for (int i = 0; i < mrtu_pkg::HDR_BYTES; i++) begin
      header_bytes_next[i] = header_bytes[i];
    end
    rx_count_next     = rx_count;
    crc_acc_next      = crc_acc;
    gap_timer_next    = gap_timer;
    end_timer_next    = end_timer;
    gap_expiries_next = gap_expiries;
    in_frame_next     = in_frame;
    overflowed_next   = overflowed;
    emit              = 1'b0;

    if (fire) begin
      if (item.req_type == mrtu_pkg::REQ_BYTE) begin
        if (!in_frame) begin
          // first byte opens a fresh frame
          for (int i = 0; i < mrtu_pkg::HDR_BYTES; i++) begin
            header_bytes_next[i] = 8'h00;
          end
          rx_count_next     = '0;
          crc_acc_next      = mrtu_pkg::CRC_INIT;
          gap_expiries_next = 2'd0;
          overflowed_next   = 1'b0;
          in_frame_next     = 1'b1;
        end
        gap_timer_next = 16'd0;
        end_timer_next = 16'd0;
        if (rx_count_next >= CW'(mrtu_pkg::FRAME_BYTES)) begin
          overflowed_next = 1'b1;
        end else begin
          for (int i = 0; i < mrtu_pkg::HDR_BYTES; i++) begin
            if (rx_count_next == CW'(i)) begin
              header_bytes_next[i] = item.rx_byte;
            end
          end
          crc_acc_next  = mrtu_pkg::crc_byte(crc_acc_next, item.rx_byte);
          rx_count_next = rx_count_next + CW'(1);
        end
      end else if (in_frame) begin
        // gap expiry is counted before the end check on the same tick
        if (gap_inc >= regs.char_gap_ticks) begin
          gap_timer_next = 16'd0;
          if (gap_expiries != 2'd3) begin
            gap_expiries_next = gap_expiries + 2'd1;
          end
        end else begin
          gap_timer_next = gap_inc;
        end
        if (end_inc >= regs.frame_end_ticks) begin
          emit           = 1'b1;
          in_frame_next  = 1'b0;
          gap_timer_next = 16'd0;
          end_timer_next = 16'd0;
        end else begin
          end_timer_next = end_inc;
        end
      end
    end
  end

  // Verdict, from the frame as it stands after this tick.
  assign reg_addr = {header_bytes[2], header_bytes[3]};
  assign val      = {header_bytes[4], header_bytes[5]};
  assign wr_addr  = {mrtu_pkg::WRITE_PAGE, reg_addr};

  always_comb begin
    addr_out = 19'd0;
    word_out = 16'd0;
    cnt_out  = 8'd0;
    if (overflowed) begin
      st = mrtu_pkg::ST_OVERFLOW;
    end else if (gap_expiries_next != 2'd2) begin
      st = mrtu_pkg::ST_TIMING;
    end else if (rx_count < CW'(mrtu_pkg::MIN_FRAME_BYTES) || crc_acc != 16'd0) begin
      st = mrtu_pkg::ST_CRC;
    end else if (header_bytes[0] != regs.slave_address) begin
      st = mrtu_pkg::ST_ADDRESS;
    end else if (header_bytes[1] == mrtu_pkg::FN_READ) begin
      st       = mrtu_pkg::ST_READ_OK;
      addr_out = {regs.read_page, reg_addr};
      word_out = val;
      cnt_out  = {val[6:0], 1'b0};
    end else if (header_bytes[1] == mrtu_pkg::FN_WRITE) begin
      addr_out = wr_addr;
      word_out = val;
      if (wr_addr >= mrtu_pkg::WRITE_LOW && wr_addr <= mrtu_pkg::WRITE_HIGH) begin
        st = mrtu_pkg::ST_WRITE_OK;
      end else begin
        st = mrtu_pkg::ST_PROTECTED;
      end
    end else begin
      st = mrtu_pkg::ST_OTHER_FN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mrtu_pkg::HDR_BYTES; i++) begin
        header_bytes[i] <= 8'h00;
      end
      rx_count     <= '0;
      crc_acc      <= mrtu_pkg::CRC_INIT;
      gap_timer    <= 16'd0;
      end_timer    <= 16'd0;
      gap_expiries <= 2'd0;
      in_frame     <= 1'b0;
      overflowed   <= 1'b0;
    end else begin
      for (int i = 0; i < mrtu_pkg::HDR_BYTES; i++) begin
        header_bytes[i] <= header_bytes_next[i];
      end
      rx_count     <= rx_count_next;
      crc_acc      <= crc_acc_next;
      gap_timer    <= gap_timer_next;
      end_timer    <= end_timer_next;
      gap_expiries <= gap_expiries_next;
      in_frame     <= in_frame_next;
      overflowed   <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.status          <= st;
      res.function_code   <= header_bytes[1];
      res.start_address   <= addr_out;
      res.word_value      <= word_out;
      res.resp_byte_count <= cnt_out;
      res.frame_length    <= 7'(rx_count);
    end
  end

endmodule

[hw/rtl/mrtu_checker.sv]
// Port-level assertions for the frame receiver, bound to the top level.
module mrtu_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  status,
  input logic [18:0] start_address,
  input logic [15:0] word_value,
  input logic [7:0]  resp_byte_count,
  input logic [6:0]  frame_length
);

  // stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(start_address))
    else $error("verdict changed while stalled");

  a_read_cnt: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == mrtu_pkg::ST_READ_OK |->
      resp_byte_count == {word_value[6:0], 1'b0})
    else $error("read byte count mismatch");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == mrtu_pkg::ST_OTHER_FN || status == mrtu_pkg::ST_TIMING ||
                  status == mrtu_pkg::ST_CRC || status == mrtu_pkg::ST_ADDRESS ||
                  status == mrtu_pkg::ST_OVERFLOW) |->
      start_address == 19'd0 && word_value == 16'd0 && resp_byte_count == 8'd0)
    else $error("unused fields not zero");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == mrtu_pkg::ST_WRITE_OK |->
      start_address >= mrtu_pkg::WRITE_LOW && resp_byte_count == 8'd0)
    else $error("accepted write outside range");

  // decoded frames passed the CRC length check
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == mrtu_pkg::ST_READ_OK || status == mrtu_pkg::ST_WRITE_OK ||
                  status == mrtu_pkg::ST_OTHER_FN || status == mrtu_pkg::ST_ADDRESS ||
                  status == mrtu_pkg::ST_PROTECTED) |->
      frame_length >= 7'(mrtu_pkg::MIN_FRAME_BYTES))
    else $error("short frame passed CRC");

endmodule

bind modbus_rtu_frame_receiver mrtu_checker u_mrtu_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .status          (res.status),
  .start_address   (res.start_address),
  .word_value      (res.word_value),
  .resp_byte_count (res.resp_byte_count),
  .frame_length    (res.frame_length)
);
